### sv/rbsi_pkg.sv
// Shared constants and types for the ray/box slab intersection unit.
package rbsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;
    localparam int CFG_IDX_W   = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

    // per-slab status carried from a lane to the merge stage
    typedef struct packed {
        logic zero;     // direction is zero on this axis
        logic outside;  // origin lies outside the slab
    } slab_flags_t;

endpackage

### sv/ray_box_slab_intersect_unit.sv
// Top level: ray versus axis-aligned box, slab method, fixed point.
// Most of the pipe from input word to result word lies in the bit-per-stage
// slab dividers.
// Throughput: one ray per cycle; the whole pipe advances when the output
// register is empty or its word is taken.
// Reset clears the box registers to zero and empties the pipe.
module ray_box_slab_intersect_unit #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_data,
    // ray in
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COORD_WIDTH-1:0]    origin_x,
    input  logic signed [COORD_WIDTH-1:0]    origin_y,
    input  logic signed [COORD_WIDTH-1:0]    origin_z,
    input  logic signed [COORD_WIDTH-1:0]    dir_x,
    input  logic signed [COORD_WIDTH-1:0]    dir_y,
    input  logic signed [COORD_WIDTH-1:0]    dir_z,
    // result out
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic                             ahead,
    output logic                             inside_res,
    output logic signed [COORD_WIDTH-1:0]    t_entry,
    output logic signed [COORD_WIDTH-1:0]    t_exit,
    output logic signed [COORD_WIDTH-1:0]    distance,
    output logic signed [COORD_WIDTH-1:0]    entry_x,
    output logic signed [COORD_WIDTH-1:0]    entry_y,
    output logic signed [COORD_WIDTH-1:0]    entry_z,
    output logic signed [COORD_WIDTH-1:0]    exit_x,
    output logic signed [COORD_WIDTH-1:0]    exit_y,
    output logic signed [COORD_WIDTH-1:0]    exit_z
);

    localparam int CW       = COORD_WIDTH;
    localparam int NA       = rbsi_pkg::NUM_AXES;
    // lane: input stage, divider (CW + 1), ordering stage
    localparam int LANE_LAT = CW + 3;
    localparam int PT_LAT   = 3;
    localparam int TOT_LAT  = LANE_LAT + 1 + PT_LAT;

    // ---------------------------------------------------------------
    // Box corner registers: user writes only while pipe is idle; not enforced.
    // ---------------------------------------------------------------
    logic signed [CW-1:0] box_min_reg [NA];
    logic signed [CW-1:0] box_max_reg [NA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NA; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbsi_pkg::REG_MIN_X: box_min_reg[0] <= cfg_data;
                rbsi_pkg::REG_MIN_Y: box_min_reg[1] <= cfg_data;
                rbsi_pkg::REG_MIN_Z: box_min_reg[2] <= cfg_data;
                rbsi_pkg::REG_MAX_X: box_max_reg[0] <= cfg_data;
                rbsi_pkg::REG_MAX_Y: box_max_reg[1] <= cfg_data;
                rbsi_pkg::REG_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;  // indexes beyond the list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipe control: one enable for every stage. The last valid bit is
    // the output register's; the pipe moves unless that word is held.
    // ---------------------------------------------------------------
    logic [TOT_LAT-1:0] vld_reg;
    logic               en;

    assign en       = !vld_reg[TOT_LAT-1] || !out_stall;
    assign in_stall = !en;
    assign out_valid = vld_reg[TOT_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT_LAT-2:0], in_valid};
    end

    // ---------------------------------------------------------------
    // Three slab lanes, one per axis.
    // ---------------------------------------------------------------
    logic signed [CW-1:0]  o_in [NA];
    logic signed [CW-1:0]  d_in [NA];
    logic signed [CW-1:0]  t_near [NA];
    logic signed [CW-1:0]  t_far  [NA];
    rbsi_pkg::slab_flags_t flags  [NA];
    logic signed [CW-1:0]  o_l [NA];
    logic signed [CW-1:0]  d_l [NA];

    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;

    for (genvar a = 0; a < NA; a++)
    begin : g_lane
        rbsi_slab_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
            .clk    (clk),
            .en     (en),
            .cmin   (box_min_reg[a]),
            .cmax   (box_max_reg[a]),
            .o      (o_in[a]),
            .d      (d_in[a]),
            .t_near (t_near[a]),
            .t_far  (t_far[a]),
            .flags  (flags[a]),
            .o_out  (o_l[a]),
            .d_out  (d_l[a])
        );
    end

    // ---------------------------------------------------------------
    // Merge: interval intersection, hit, distance and flags.
    // ---------------------------------------------------------------
    logic                 m_hit, m_ahead, m_inside;
    logic signed [CW-1:0] m_entry, m_exit, m_dist;
    logic signed [CW-1:0] o_m_reg [NA];
    logic signed [CW-1:0] d_m_reg [NA];

    rbsi_merge #(.CW(CW)) u_merge (
        .clk        (clk),
        .en         (en),
        .t_near     (t_near),
        .t_far      (t_far),
        .flags      (flags),
        .hit        (m_hit),
        .ahead      (m_ahead),
        .inside_res (m_inside),
        .t_entry    (m_entry),
        .t_exit     (m_exit),
        .distance   (m_dist)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NA; a++)
            begin
                o_m_reg[a] <= o_l[a];
                d_m_reg[a] <= d_l[a];
            end
        end
    end

    // ---------------------------------------------------------------
    // Entry and exit points, one multiplier lane per axis and end.
    // ---------------------------------------------------------------
    logic signed [CW-1:0] p_entry [NA];
    logic signed [CW-1:0] p_exit  [NA];

    for (genvar a = 0; a < NA; a++)
    begin : g_pt
        rbsi_point #(.CW(CW), .FB(FRAC_BITS)) u_pt_entry (
            .clk (clk),
            .en  (en),
            .o   (o_m_reg[a]),
            .t   (m_entry),
            .d   (d_m_reg[a]),
            .pt  (p_entry[a])
        );
        rbsi_point #(.CW(CW), .FB(FRAC_BITS)) u_pt_exit (
            .clk (clk),
            .en  (en),
            .o   (o_m_reg[a]),
            .t   (m_exit),
            .d   (d_m_reg[a]),
            .pt  (p_exit[a])
        );
    end

    // Scalar results wait alongside the point lanes.
    logic                 hit_reg    [PT_LAT];
    logic                 ahead_reg  [PT_LAT];
    logic                 inside_reg [PT_LAT];
    logic signed [CW-1:0] entry_reg  [PT_LAT];
    logic signed [CW-1:0] exit_reg   [PT_LAT];
    logic signed [CW-1:0] dist_reg   [PT_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg[0]    <= m_hit;
            ahead_reg[0]  <= m_ahead;
            inside_reg[0] <= m_inside;
            entry_reg[0]  <= m_entry;
            exit_reg[0]   <= m_exit;
            dist_reg[0]   <= m_dist;
            for (int k = 1; k < PT_LAT; k++)
            begin
                hit_reg[k]    <= hit_reg[k-1];
                ahead_reg[k]  <= ahead_reg[k-1];
                inside_reg[k] <= inside_reg[k-1];
                entry_reg[k]  <= entry_reg[k-1];
                exit_reg[k]   <= exit_reg[k-1];
                dist_reg[k]   <= dist_reg[k-1];
            end
        end
    end

    // A miss reports zero in every field.
    logic h;
    assign h = hit_reg[PT_LAT-1];

    assign hit        = h;
    assign ahead      = ahead_reg[PT_LAT-1];
    assign inside_res = inside_reg[PT_LAT-1];
    assign t_entry    = h ? entry_reg[PT_LAT-1] : '0;
    assign t_exit     = h ? exit_reg[PT_LAT-1]  : '0;
    assign distance   = h ? dist_reg[PT_LAT-1]  : '0;
    assign entry_x    = h ? p_entry[0] : '0;
    assign entry_y    = h ? p_entry[1] : '0;
    assign entry_z    = h ? p_entry[2] : '0;
    assign exit_x     = h ? p_exit[0]  : '0;
    assign exit_y     = h ? p_exit[1]  : '0;
    assign exit_z     = h ? p_exit[2]  : '0;

endmodule

### sv/rbsi_div_pipe.sv
// Pipelined restoring divider: (num << FB) / den, signed result, saturated.
module rbsi_div_pipe #(
    parameter int CW = rbsi_pkg::COORD_WIDTH,
    parameter int FB = rbsi_pkg::FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [CW:0]          num_mag,
    input  logic [CW-1:0]        den_mag,
    input  logic                 neg,
    output logic signed [CW-1:0] quo
);

    localparam int NW   = CW + 1 + FB;
    localparam int DW   = 2 * CW - 1;
    localparam int CMPW = (NW > DW) ? NW : DW;
    localparam int NSTG = CW - 1;
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic [CMPW-1:0] rem_reg [NSTG+1];
    logic [CW-1:0]   den_reg [NSTG+1];
    logic [CW-2:0]   q_reg   [NSTG+1];
    logic            neg_reg [NSTG+1];
    logic            sat_reg [NSTG+1];
    logic signed [CW-1:0] quo_reg;

    logic [CMPW-1:0] num_sh;
    logic [CMPW-1:0] lim;

    assign num_sh = CMPW'(num_mag) << FB;
    assign lim    = CMPW'(den_mag) << (CW - 1);

    // quotient of 2^(CW-1) or more saturates; else all bits fit below that
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_sh;
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            sat_reg[0] <= (num_sh >= lim);
        end
    end

    for (genvar k = 1; k <= NSTG; k++)
    begin : g_bit
        localparam int B = NSTG - k;
        logic [CMPW-1:0] sub;
        logic            take;
        assign sub  = CMPW'(den_reg[k-1]) << B;
        assign take = (rem_reg[k-1] >= sub);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - sub) : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | ((CW-1)'(take) << B);
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sat_reg[NSTG])
                quo_reg <= neg_reg[NSTG] ? MINV : MAXV;
            else if (neg_reg[NSTG])
                quo_reg <= -$signed({1'b0, q_reg[NSTG]});
            else
                quo_reg <= $signed({1'b0, q_reg[NSTG]});
        end
    end

    assign quo = quo_reg;

endmodule

### sv/rbsi_slab_lane.sv
// One axis: slab bounds, two slab divisions, near/far ordering.
module rbsi_slab_lane #(
    parameter int CW = rbsi_pkg::COORD_WIDTH,
    parameter int FB = rbsi_pkg::FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] cmin,
    input  logic signed [CW-1:0] cmax,
    input  logic signed [CW-1:0] o,
    input  logic signed [CW-1:0] d,
    output logic signed [CW-1:0] t_near,
    output logic signed [CW-1:0] t_far,
    output rbsi_pkg::slab_flags_t flags,
    output logic signed [CW-1:0] o_out,
    output logic signed [CW-1:0] d_out
);

    localparam int DIV_LAT = CW + 1;

    logic signed [CW-1:0] lo, hi;
    logic signed [CW:0]   n_lo, n_hi;
    logic [CW:0]          mag_lo, mag_hi;
    logic [CW-1:0]        dmag;
    rbsi_pkg::slab_flags_t flags_in;

    assign lo = (cmin < cmax) ? cmin : cmax;
    assign hi = (cmin < cmax) ? cmax : cmin;
    assign n_lo = {lo[CW-1], lo} - {o[CW-1], o};
    assign n_hi = {hi[CW-1], hi} - {o[CW-1], o};
    assign mag_lo = n_lo[CW] ? (CW+1)'(-n_lo) : (CW+1)'(n_lo);
    assign mag_hi = n_hi[CW] ? (CW+1)'(-n_hi) : (CW+1)'(n_hi);
    assign dmag   = d[CW-1] ? CW'(-d) : CW'(d);
    assign flags_in.zero    = (d == '0);
    assign flags_in.outside = (o < lo) || (o > hi);

    logic [CW:0]          mag_lo_reg, mag_hi_reg;
    logic                 neg_lo_reg, neg_hi_reg;
    logic [CW-1:0]        dmag_reg;
    rbsi_pkg::slab_flags_t flags_reg [DIV_LAT+1];
    logic signed [CW-1:0] o_reg [DIV_LAT+1];
    logic signed [CW-1:0] d_reg [DIV_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_lo_reg   <= mag_lo;
            mag_hi_reg   <= mag_hi;
            neg_lo_reg   <= n_lo[CW] ^ d[CW-1];
            neg_hi_reg   <= n_hi[CW] ^ d[CW-1];
            dmag_reg     <= dmag;
            flags_reg[0] <= flags_in;
            o_reg[0]     <= o;
            d_reg[0]     <= d;
        end
    end

    // sideband rides alongside the dividers
    for (genvar k = 1; k <= DIV_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flags_reg[k] <= flags_reg[k-1];
                o_reg[k]     <= o_reg[k-1];
                d_reg[k]     <= d_reg[k-1];
            end
        end
    end

    logic signed [CW-1:0] t1, t2;

    rbsi_div_pipe #(.CW(CW), .FB(FB)) u_div_lo (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_lo_reg),
        .den_mag (dmag_reg),
        .neg     (neg_lo_reg),
        .quo     (t1)
    );

    rbsi_div_pipe #(.CW(CW), .FB(FB)) u_div_hi (
        .clk     (clk),
        .en      (en),
        .num_mag (mag_hi_reg),
        .den_mag (dmag_reg),
        .neg     (neg_hi_reg),
        .quo     (t2)
    );

    logic signed [CW-1:0] near_reg, far_reg, o_q_reg, d_q_reg;
    rbsi_pkg::slab_flags_t flags_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg    <= (t1 < t2) ? t1 : t2;
            far_reg     <= (t1 < t2) ? t2 : t1;
            flags_q_reg <= flags_reg[DIV_LAT];
            o_q_reg     <= o_reg[DIV_LAT];
            d_q_reg     <= d_reg[DIV_LAT];
        end
    end

    assign t_near = near_reg;
    assign t_far  = far_reg;
    assign flags  = flags_q_reg;
    assign o_out  = o_q_reg;
    assign d_out  = d_q_reg;

endmodule

### sv/rbsi_merge.sv
// Merges the three slab intervals into the hit test, interval and distance.
module rbsi_merge #(
    parameter int CW = rbsi_pkg::COORD_WIDTH
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] t_near [rbsi_pkg::NUM_AXES],
    input  logic signed [CW-1:0] t_far  [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::slab_flags_t flags [rbsi_pkg::NUM_AXES],
    output logic                 hit,
    output logic                 ahead,
    output logic                 inside_res,
    output logic signed [CW-1:0] t_entry,
    output logic signed [CW-1:0] t_exit,
    output logic signed [CW-1:0] distance
);

    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] ent, lea;
    logic                 miss;

    always_comb
    begin
        ent  = MINV;
        lea  = MAXV;
        miss = 1'b0;
        for (int a = 0; a < rbsi_pkg::NUM_AXES; a++)
        begin
            if (flags[a].zero)
            begin
                if (flags[a].outside)
                    miss = 1'b1;
            end
            else
            begin
                if (t_near[a] > ent)
                    ent = t_near[a];
                if (t_far[a] < lea)
                    lea = t_far[a];
            end
        end
        if (ent > lea)
            miss = 1'b1;
    end

    logic                 hit_reg, ahead_reg, inside_reg;
    logic signed [CW-1:0] entry_reg, exit_reg, dist_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg    <= !miss;
            ahead_reg  <= !miss && !lea[CW-1];
            inside_reg <= !miss && ent[CW-1];
            entry_reg  <= ent;
            exit_reg   <= lea;
            dist_reg   <= ent[CW-1] ? lea : ent;
        end
    end

    assign hit        = hit_reg;
    assign ahead      = ahead_reg;
    assign inside_res = inside_reg;
    assign t_entry    = entry_reg;
    assign t_exit     = exit_reg;
    assign distance   = dist_reg;

endmodule

### sv/rbsi_point.sv
// Point on the ray: o + trunc(t * d / 2^FB), saturated; three stages.
module rbsi_point #(
    parameter int CW = rbsi_pkg::COORD_WIDTH,
    parameter int FB = rbsi_pkg::FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] o,
    input  logic signed [CW-1:0] t,
    input  logic signed [CW-1:0] d,
    output logic signed [CW-1:0] pt
);

    localparam int PW = 2 * CW;
    localparam int MW = PW - FB;
    localparam int SW = PW + 1;
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX = SW'(MAXV);
    localparam logic signed [SW-1:0] SMIN = SW'(MINV);

    logic [CW-1:0]        a_reg, b_reg;
    logic                 s1_reg, s2_reg;
    logic signed [CW-1:0] o1_reg, o2_reg, pt_reg;
    logic [PW-1:0]        prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= t[CW-1] ? CW'(-t) : CW'(t);
            b_reg  <= d[CW-1] ? CW'(-d) : CW'(d);
            s1_reg <= t[CW-1] ^ d[CW-1];
            o1_reg <= o;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(a_reg) * PW'(b_reg);
            s2_reg   <= s1_reg;
            o2_reg   <= o1_reg;
        end
    end

    logic [MW-1:0]        mag;
    logic signed [SW-1:0] term, sum;

    assign mag  = prod_reg[PW-1:FB];
    assign term = s2_reg ? -$signed(SW'(mag)) : $signed(SW'(mag));
    assign sum  = SW'(o2_reg) + term;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sum > SMAX)
                pt_reg <= MAXV;
            else if (sum < SMIN)
                pt_reg <= MINV;
            else
                pt_reg <= sum[CW-1:0];
        end
    end

    assign pt = pt_reg;

endmodule

### bench/ray_box_slab_intersect_unit_tb.sv
// Self-checking bench for the ray/box slab intersection unit.
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_tb;

    localparam int  CW         = rbsi_pkg::COORD_WIDTH;
    localparam int  FB         = rbsi_pkg::FRAC_BITS;
    localparam int  LATENCY    = CW + 7;
    localparam int  DOG_LIMIT  = 4000;
    localparam longint S_MAX   = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint S_MIN   = -S_MAX - 1;
    localparam longint ONE     = longint'(1) <<< FB;

    // indexes past the last corner register
    localparam logic [rbsi_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [rbsi_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef logic signed [CW-1:0] coord_t;

    // one expected result word
    typedef struct packed {
        logic   hit;
        logic   ahead;
        logic   in_box;
        coord_t t_in;
        coord_t t_out;
        coord_t t_dist;
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
    } hit_report_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    logic [rbsi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic   in_valid;
    logic   in_stall;
    coord_t origin_x, origin_y, origin_z;
    coord_t dir_x, dir_y, dir_z;
    logic   out_valid;
    logic   out_stall;
    logic   hit, ahead, inside_res;
    coord_t t_entry, t_exit, distance;
    coord_t entry_x, entry_y, entry_z;
    coord_t exit_x, exit_y, exit_z;

    // bench-side copy of the six corner registers, indexed like the port
    coord_t      box_regs [6];
    hit_report_t pending_reports[$];
    int          fail_count;
    int          rays_sent;
    int          reports_seen;
    int          hits_seen;
    int          dog_count;
    int          stall_left;
    bit          tx_idle;     // sender inserts gaps in this phase
    bit          rx_idle;     // receiver stalls in this phase

    ray_box_slab_intersect_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .origin_z  (origin_z),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .ahead     (ahead),
        .inside_res(inside_res),
        .t_entry   (t_entry),
        .t_exit    (t_exit),
        .distance  (distance),
        .entry_x   (entry_x),
        .entry_y   (entry_y),
        .entry_z   (entry_z),
        .exit_x    (exit_x),
        .exit_y    (exit_y),
        .exit_z    (exit_z)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the slab test
    // ------------------------------------------------------------------
    function automatic longint clamp_coord(longint v);
        if (v > S_MAX)
            return S_MAX;
        if (v < S_MIN)
            return S_MIN;
        return v;
    endfunction

    // (num << FB) / den, truncated toward zero, clamped to the coord range
    function automatic longint slab_param(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        bit neg;
        n   = (num < 0) ? longint'(-num) : num;
        d   = (den < 0) ? longint'(-den) : den;
        neg = (num < 0) != (den < 0);
        q   = (n << FB) / d;
        if (neg)
            return (q >= longint'(S_MAX) + 1) ? S_MIN : -longint'(q);
        return (q > S_MAX) ? S_MAX : longint'(q);
    endfunction

    // origin + t * dir, product truncated toward zero, sum clamped
    function automatic longint ray_point(longint o, longint t, longint d);
        longint unsigned a;
        longint unsigned b;
        longint unsigned p;
        longint term;
        a    = (t < 0) ? longint'(-t) : t;
        b    = (d < 0) ? longint'(-d) : d;
        p    = (a * b) >> FB;
        term = ((t < 0) != (d < 0)) ? -longint'(p) : longint'(p);
        return clamp_coord(o + term);
    endfunction

    function automatic hit_report_t intersect_ray(coord_t ox, coord_t oy, coord_t oz,
                                                  coord_t dx, coord_t dy, coord_t dz);
        hit_report_t r;
        longint o[3];
        longint d[3];
        longint lo, hi, t1, t2, t_near, t_far;
        longint t_lo;
        longint t_hi;
        bit     crosses;
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        t_lo    = S_MIN;
        t_hi    = S_MAX;
        crosses = 1'b1;
        r       = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            // swapped corners: smaller register is the lower plane
            lo = box_regs[ax];
            hi = box_regs[ax + 3];
            if (hi < lo)
            begin
                lo = box_regs[ax + 3];
                hi = box_regs[ax];
            end
            if (d[ax] == 0)
            begin
                // parallel ray: unbounded slab or clean miss
                if (o[ax] < lo || o[ax] > hi)
                    crosses = 1'b0;
            end
            else
            begin
                t1     = slab_param(lo - o[ax], d[ax]);
                t2     = slab_param(hi - o[ax], d[ax]);
                t_near = (t1 < t2) ? t1 : t2;
                t_far  = (t1 < t2) ? t2 : t1;
                if (t_near > t_lo)
                    t_lo = t_near;
                if (t_far < t_hi)
                    t_hi = t_far;
            end
        end
        if (t_lo > t_hi)
            crosses = 1'b0;
        if (!crosses)
            return r;   // miss: everything reads zero
        r.hit    = 1'b1;
        r.ahead  = t_hi >= 0;
        r.in_box = t_lo < 0;
        r.t_in   = coord_t'(t_lo);
        r.t_out  = coord_t'(t_hi);
        r.t_dist = coord_t'((t_lo >= 0) ? t_lo : t_hi);
        r.in_x   = coord_t'(ray_point(o[0], t_lo, d[0]));
        r.in_y   = coord_t'(ray_point(o[1], t_lo, d[1]));
        r.in_z   = coord_t'(ray_point(o[2], t_lo, d[2]));
        r.out_x  = coord_t'(ray_point(o[0], t_hi, d[0]));
        r.out_y  = coord_t'(ray_point(o[1], t_hi, d[1]));
        r.out_z  = coord_t'(ray_point(o[2], t_hi, d[2]));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        hit_report_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            stall_left = rx_idle ? $urandom_range(0, 15) : 0;
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("result word with no ray outstanding");
                fail_count++;
            end
            else
            begin
                e = pending_reports.pop_front();
                hits_seen += e.hit;
                cmp_field("hit", e.hit, hit);
                cmp_field("ahead", e.ahead, ahead);
                cmp_field("inside_res", e.in_box, inside_res);
                cmp_field("t_entry", e.t_in, t_entry);
                cmp_field("t_exit", e.t_out, t_exit);
                cmp_field("distance", e.t_dist, distance);
                cmp_field("entry_x", e.in_x, entry_x);
                cmp_field("entry_y", e.in_y, entry_y);
                cmp_field("entry_z", e.in_z, entry_z);
                cmp_field("exit_x", e.out_x, exit_x);
                cmp_field("exit_y", e.out_y, exit_y);
                cmp_field("exit_z", e.out_z, exit_z);
            end
        end
    end

    // receiver: stall for the drawn number of cycles before each word
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
            out_stall = 1'b0;
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            dog_count = 0;
        else if (++dog_count >= DOG_LIMIT)
        begin
            $display("ray_box_slab_intersect_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_ray(longint ox, longint oy, longint oz,
                            longint dx, longint dy, longint dz);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        origin_x = coord_t'(ox); origin_y = coord_t'(oy); origin_z = coord_t'(oz);
        dir_x    = coord_t'(dx); dir_y    = coord_t'(dy); dir_z    = coord_t'(dz);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_reports.insert(pending_reports.size(),
                               intersect_ray(coord_t'(ox), coord_t'(oy), coord_t'(oz),
                                             coord_t'(dx), coord_t'(dy), coord_t'(dz)));
        rays_sent++;
    endtask

    // hold the sender until every outstanding word has come back
    task automatic drain_pipe();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(logic [rbsi_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[CW-1:0];
        if (idx <= rbsi_pkg::REG_MAX_Z)
            box_regs[idx] = coord_t'(val);   // higher indexes are ignored by the block
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_box(longint x0, longint y0, longint z0,
                            longint x1, longint y1, longint z1);
        drain_pipe();
        write_reg(rbsi_pkg::REG_MIN_X, x0);
        write_reg(rbsi_pkg::REG_MIN_Y, y0);
        write_reg(rbsi_pkg::REG_MIN_Z, z0);
        write_reg(rbsi_pkg::REG_MAX_X, x1);
        write_reg(rbsi_pkg::REG_MAX_Y, y1);
        write_reg(rbsi_pkg::REG_MAX_Z, z1);
    endtask

    function automatic longint any_coord();
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return 0;
            3: return $urandom_range(0, 1) ? 1 : -1;
            4, 5: return $signed($urandom_range(0, 200 * ONE)) - 100 * ONE;
            default: return longint'(coord_t'($urandom));
        endcase
    endfunction

    // direction: mostly moderate, sometimes zero or extreme
    function automatic longint any_dir();
        case ($urandom_range(0, 9))
            0, 1: return 0;
            2: return any_coord();
            default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
        endcase
    endfunction

    // ray aimed at a point inside the box, with a random stretch
    task automatic send_aimed_ray();
        longint o[3];
        longint dv[3];
        longint lo, hi, tgt;
        for (int ax = 0; ax < 3; ax++)
        begin
            lo = box_regs[ax];
            hi = box_regs[ax + 3];
            if (hi < lo)
            begin
                lo = box_regs[ax + 3];
                hi = box_regs[ax];
            end
            tgt    = lo + ((hi - lo) / 1000) * $urandom_range(0, 1000);
            o[ax]  = ($urandom_range(0, 3) == 0) ? any_coord()
                   : clamp_coord(tgt + $signed($urandom_range(0, 80 * ONE)) - 40 * ONE);
            dv[ax] = clamp_coord((tgt - o[ax]) >>> $urandom_range(0, 4));
            if ($urandom_range(0, 11) == 0)
                dv[ax] = 0;
        end
        send_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_box();
        // degenerate point box at the origin, straight after reset
        send_ray(-ONE, 0, 0, ONE, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(ONE, ONE, 0, 0, 0, ONE);
    endtask

    task automatic test_directed();
        load_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_ray(-4 * ONE, 0, 0, ONE, 0, 0);
        send_ray(4 * ONE, 0, 0, -ONE, 0, 0);
        send_ray(0, -4 * ONE, 0, 0, 2 * ONE, 0);
        send_ray(0, 0, 4 * ONE, 0, 0, -ONE / 2);
        send_ray(0, 0, 0, ONE, ONE, ONE);                  // starts inside
        send_ray(0, 0, 0, 0, 0, 0);                        // all zero, inside
        send_ray(5 * ONE, 0, 0, 0, 0, 0);                  // all zero, outside
        send_ray(0, 3 * ONE, 0, ONE, 0, 0);                // parallel, outside slab
        send_ray(-3 * ONE, -3 * ONE, 0, ONE, ONE / 2, 0);  // touches an edge
        send_ray(-3 * ONE, ONE, 0, ONE, 0, 0);             // grazes a face
        send_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE); // corner to corner
        send_ray(4 * ONE, 0, 0, ONE, 0, 0);                // box behind the ray
        send_ray(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
        send_ray(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN);
        send_ray(-ONE, 0, 0, 1, 0, 0);                     // tiny dir, t saturates
        send_ray(0, 0, 0, -1, 1, -1);
        send_ray(S_MIN, 0, 0, 1, 0, 0);
        send_ray(-1, -1, -1, S_MIN, S_MAX, S_MIN);
    endtask

    task automatic test_config_extremes();
        // swapped corners on every axis
        load_box(2 * ONE, 3 * ONE, ONE, -2 * ONE, -ONE, -3 * ONE);
        send_ray(-8 * ONE, 0, 0, ONE, 0, 0);
        send_ray(0, 0, 0, ONE, ONE, -ONE);
        // widest box the registers hold
        load_box(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX);
        send_ray(0, 0, 0, ONE, -ONE, ONE);
        send_ray(S_MIN, S_MAX, 0, 1, -1, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        // indexes past the last register leave the box untouched
        drain_pipe();
        write_reg(REG_SPARE_A, longint'(32'h1234_5678));
        write_reg(REG_SPARE_B, S_MIN);
        send_ray(S_MAX, S_MIN, 0, -ONE, ONE, 0);
    endtask

    task automatic test_random(int count);
        int phase_left;
        longint cx, cy, cz, hx, hy, hz;
        phase_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (phase_left == 0)
            begin
                // new box: mostly small near the origin, sometimes anything
                cx = $signed($urandom_range(0, 100 * ONE)) - 50 * ONE;
                cy = $signed($urandom_range(0, 100 * ONE)) - 50 * ONE;
                cz = $signed($urandom_range(0, 100 * ONE)) - 50 * ONE;
                hx = $urandom_range(0, 20 * ONE);
                hy = $urandom_range(0, 20 * ONE);
                hz = $urandom_range(0, 20 * ONE);
                if ($urandom_range(0, 4) == 0)
                    load_box(any_coord(), any_coord(), any_coord(),
                             any_coord(), any_coord(), any_coord());
                else if ($urandom_range(0, 1))
                    load_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
                else
                    load_box(cx + hx, cy - hy, cz + hz, cx - hx, cy + hy, cz - hz);
                tx_idle    = $urandom_range(0, 3) != 0;
                rx_idle    = $urandom_range(0, 3) != 0;
                phase_left = $urandom_range(80, 200);
            end
            if ($urandom_range(0, 3) != 0)
                send_aimed_ray();
            else
                send_ray(any_coord(), any_coord(), any_coord(),
                         any_dir(), any_dir(), any_dir());
            phase_left--;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        origin_x   = '0; origin_y = '0; origin_z = '0;
        dir_x      = '0; dir_y    = '0; dir_z    = '0;
        fail_count = 0;
        rays_sent  = 0;
        reports_seen = 0;
        hits_seen  = 0;
        dog_count  = 0;
        stall_left = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        foreach (box_regs[k])
            box_regs[k] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_box();
        test_directed();
        test_config_extremes();
        test_random(1650);

        drain_pipe();
        $display("Covered %0d rays (%0d hits) over directed, swapped, extreme and random boxes,",
                 rays_sent, hits_seen);
        $display("with random sender gaps and receiver stalls; %0d result words checked.",
                 reports_seen);
        if (fail_count == 0)
            $display("ray_box_slab_intersect_unit test passed");
        else
            $display("ray_box_slab_intersect_unit test failed");
        $finish;
    end

endmodule
